// ===== sv/sbfd_pkg.sv =====
`timescale 1ns / 1ps

package sbfd_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 9;
    localparam int RATE_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_ENABLE = 2'd1;

    // Input mode and result kind codes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_RATE = 1'b1;

    // Fixed frame positions
    localparam logic [POS_W-1:0] POS_START = 9'd0;
    localparam logic [POS_W-1:0] POS_TYPE  = 9'd1;
    localparam logic [POS_W-1:0] POS_LEN   = 9'd2;
    localparam logic [POS_W-1:0] POS_BODY  = 9'd3;

    localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] frame_kind;
        logic              frame_end;
        logic [RATE_W-1:0] message_rate;
    } t_result;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [BYTE_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

// ===== sv/sbfd_in_if.sv =====
`timescale 1ns / 1ps

interface sbfd_in_if import sbfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== sv/sbfd_out_if.sv =====
`timescale 1ns / 1ps

interface sbfd_out_if import sbfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] frame_kind;
    logic              frame_end;
    logic [RATE_W-1:0] message_rate;

    modport source (output valid, output kind, output frame_byte, output byte_position,
                    output frame_kind, output frame_end, output message_rate,
                    input ready);
    modport sink   (input valid, input kind, input frame_byte, input byte_position,
                    input frame_kind, input frame_end, input message_rate,
                    output ready);
endinterface

// ===== sv/sbfd_cfg_if.sv =====
`timescale 1ns / 1ps

interface sbfd_cfg_if import sbfd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/start_byte_frame_deframer.sv =====
`timescale 1ns / 1ps
// A result is registered in the output stage, or parked in its skid entry, before it reaches the output.
// Throughput: one item per cycle while the skid stage is free; the parse state updates in the transfer cycle.
// A two-entry output stage keeps input open while one result waits downstream.
// Reset (synchronous, active low) clears parse state, counters and config to 0.
// Configuration writes are always ready and take effect the next cycle.
module start_byte_frame_deframer import sbfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbfd_in_if.sink     i_in,
    sbfd_out_if.source  o_out,
    sbfd_cfg_if.sink    i_cfg
);

    t_cfg_wr     w_cfg_wr;
    t_result     w_res;
    t_result     w_out;
    t_buf_status w_status;
    logic        w_res_valid;
    logic        w_accept;

    // Config channel never stalls
    assign i_cfg.ready    = 1'b1;
    assign w_cfg_wr.en    = i_cfg.valid;
    assign w_cfg_wr.index = i_cfg.index;
    assign w_cfg_wr.data  = i_cfg.data;

    // Accept while the skid stage is free
    assign i_in.ready = !w_status.skid_valid;
    assign w_accept   = i_in.valid & i_in.ready;

    sbfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (w_cfg_wr),
        .i_accept    (w_accept),
        .i_mode      (i_in.mode),
        .i_rx_byte   (i_in.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sbfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_data      (w_res),
        .i_pop_ready (o_out.ready),
        .o_valid     (o_out.valid),
        .o_data      (w_out),
        .o_status    (w_status)
    );

    assign o_out.kind          = w_out.kind;
    assign o_out.frame_byte    = w_out.frame_byte;
    assign o_out.byte_position = w_out.byte_position;
    assign o_out.frame_kind    = w_out.frame_kind;
    assign o_out.frame_end     = w_out.frame_end;
    assign o_out.message_rate  = w_out.message_rate;

    // Skid stage fills only behind a held output
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.skid_valid |-> w_status.main_valid)
        else $error("skid entry without output entry");

    // Tick into an empty buffer shows a rate report next cycle
    a_tick_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode == MODE_TICK && !w_status.main_valid)
        |=> (o_out.valid && o_out.kind == KIND_RATE))
        else $error("tick did not produce a rate report");

    // Frame end marks only frame byte results
    a_end_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> (o_out.kind == KIND_BYTE))
        else $error("frame end on a rate report");

    // Start byte carries no frame type yet
    a_start_no_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_BYTE && o_out.byte_position == POS_START)
        |-> (o_out.frame_kind == '0))
        else $error("frame type on start byte");

endmodule

// ===== sv/sbfd_parser.sv =====
`timescale 1ns / 1ps

module sbfd_parser import sbfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg_wr,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [BYTE_W-1:0] r_start_marker;
    logic              r_capture_enable;
    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [POS_W-1:0]  r_remaining, n_remaining;
    logic [POS_W-1:0]  r_position, n_position;
    logic [RATE_W-1:0] r_frames, n_frames;
    logic [RATE_W-1:0] r_rate, n_rate;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker   <= '0;
            r_capture_enable <= 1'b0;
        end else if (i_cfg_wr.en) begin
            case (i_cfg_wr.index)
                REG_START_MARKER:   r_start_marker   <= i_cfg_wr.data;
                REG_CAPTURE_ENABLE: r_capture_enable <= i_cfg_wr.data[0];
                default: ;
            endcase
        end
    end

    // Parse state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_type      <= '0;
            r_remaining <= '0;
            r_position  <= '0;
            r_frames    <= '0;
            r_rate      <= '0;
        end else begin
            r_phase     <= n_phase;
            r_type      <= n_type;
            r_remaining <= n_remaining;
            r_position  <= n_position;
            r_frames    <= n_frames;
            r_rate      <= n_rate;
        end
    end

    // Next state and result for one accepted item
    always_comb begin
        n_phase     = r_phase;
        n_type      = r_type;
        n_remaining = r_remaining;
        n_position  = r_position;
        n_frames    = r_frames;
        n_rate      = r_rate;
        o_res_valid = 1'b0;

        o_res.kind          = KIND_BYTE;
        o_res.frame_byte    = i_rx_byte;
        o_res.byte_position = r_position;
        o_res.frame_kind    = r_type;
        o_res.frame_end     = 1'b0;
        o_res.message_rate  = r_rate;

        if (i_accept) begin
            if (i_mode == MODE_TICK) begin
                // Latch the count as the rate and restart counting
                n_rate              = r_frames;
                n_frames            = '0;
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_RATE;
                o_res.frame_byte    = '0;
                o_res.byte_position = '0;
                o_res.frame_kind    = '0;
                o_res.message_rate  = r_frames;
            end else if (r_capture_enable) begin
                case (r_phase)
                    PH_HUNT: begin
                        // Drop anything but the start marker
                        if (i_rx_byte == r_start_marker) begin
                            n_type              = '0;
                            n_remaining         = '0;
                            n_position          = POS_TYPE;
                            n_phase             = PH_TYPE;
                            o_res_valid         = 1'b1;
                            o_res.byte_position = POS_START;
                            o_res.frame_kind    = '0;
                        end
                    end
                    PH_TYPE: begin
                        n_type              = i_rx_byte;
                        n_position          = POS_LEN;
                        n_phase             = PH_LEN;
                        o_res_valid         = 1'b1;
                        o_res.byte_position = POS_TYPE;
                        o_res.frame_kind    = i_rx_byte;
                    end
                    PH_LEN: begin
                        // Payload bytes plus the check byte
                        n_remaining         = {1'b0, i_rx_byte} + 9'd1;
                        n_position          = POS_BODY;
                        n_phase             = PH_BODY;
                        o_res_valid         = 1'b1;
                        o_res.byte_position = POS_LEN;
                    end
                    PH_BODY: begin
                        o_res_valid = 1'b1;
                        if (r_remaining <= 9'd1) begin
                            // Check byte closes the frame
                            n_remaining     = '0;
                            n_position      = '0;
                            n_phase         = PH_HUNT;
                            o_res.frame_end = 1'b1;
                            if (r_frames != RATE_MAX) begin
                                n_frames = r_frames + 16'd1;
                            end
                        end else begin
                            n_remaining = r_remaining - 9'd1;
                            n_position  = r_position + 9'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/sbfd_out_buf.sv =====
`timescale 1ns / 1ps

module sbfd_out_buf import sbfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_result     i_data,
    input  logic        i_pop_ready,
    output logic        o_valid,
    output t_result     o_data,
    output t_buf_status o_status
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    w_pop;

    assign w_pop = r_main_valid & i_pop_ready;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || w_pop) begin
            r_main_valid <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: refill the output from the skid stage first, else park new result
    always_ff @(posedge i_clk) begin
        if (!r_main_valid || w_pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid             = r_main_valid;
    assign o_data              = r_main;
    assign o_status.main_valid = r_main_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sbfd_pkg::*;

    localparam int     CLK_HALF        = 5;
    localparam int     RESET_CYCLES    = 4;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     TAIL_CYCLES     = 8;
    localparam int     HOLD_OFF_CYCLES = 200;
    localparam int     RANDOM_ITEMS    = 1250;
    localparam int     RANDOM_PHASES   = 5;
    localparam longint RUN_LIMIT_NS    = 64'd20_000_000;

    // Indexes past the register map; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // Predicts the deframer output and holds the results still due
    class frame_scoreboard;
        logic [BYTE_W-1:0] marker;
        logic              capture_on;
        t_phase            phase;
        logic [BYTE_W-1:0] cur_type;
        logic [POS_W-1:0]  remaining;
        logic [POS_W-1:0]  next_pos;
        logic [RATE_W-1:0] frame_count;
        logic [RATE_W-1:0] rate;
        t_result           expected_q[$];
        int                errors;
        int                active_items;
        int                results_checked;
        int                frames_done;
        int                rate_reports;
        int                peak_rate;

        function new();
            marker          = '0;
            capture_on      = 1'b0;
            phase           = PH_HUNT;
            cur_type        = '0;
            remaining       = '0;
            next_pos        = '0;
            frame_count     = '0;
            rate            = '0;
            errors          = 0;
            active_items    = 0;
            results_checked = 0;
            frames_done     = 0;
            rate_reports    = 0;
            peak_rate       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (idx)
                REG_START_MARKER:   marker = data;
                REG_CAPTURE_ENABLE: capture_on = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Zero bytes needed to bring the parser back to hunting
        function int bytes_to_finish();
            case (phase)
                PH_HUNT: return 0;
                PH_TYPE: return 3;
                PH_LEN:  return 2;
                default: return int'(remaining);
            endcase
        endfunction

        // Advance the parse state for one accepted transfer
        function void note_input(logic mode, logic [BYTE_W-1:0] b);
            t_result r;
            r = '0;
            if (mode == MODE_TICK) begin
                rate        = frame_count;
                frame_count = '0;
                if (int'(rate) > peak_rate) peak_rate = int'(rate);
                r.kind         = KIND_RATE;
                r.message_rate = rate;
                expected_q.push_back(r);
                active_items++;
                rate_reports++;
                return;
            end
            if (!capture_on) return;
            r.kind       = KIND_BYTE;
            r.frame_byte = b;
            case (phase)
                PH_HUNT: begin
                    if (b != marker) return;
                    cur_type        = '0;
                    remaining       = '0;
                    next_pos        = POS_TYPE;
                    phase           = PH_TYPE;
                    r.byte_position = POS_START;
                end
                PH_TYPE: begin
                    cur_type        = b;
                    next_pos        = POS_LEN;
                    phase           = PH_LEN;
                    r.byte_position = POS_TYPE;
                end
                PH_LEN: begin
                    remaining       = {1'b0, b} + 9'd1;
                    next_pos        = POS_BODY;
                    phase           = PH_BODY;
                    r.byte_position = POS_LEN;
                end
                default: begin
                    r.byte_position = next_pos;
                    next_pos        = next_pos + 9'd1;
                    if (remaining <= 9'd1) begin
                        remaining   = '0;
                        phase       = PH_HUNT;
                        next_pos    = '0;
                        r.frame_end = 1'b1;
                        if (frame_count != RATE_MAX) frame_count = frame_count + 16'd1;
                        frames_done++;
                    end else begin
                        remaining = remaining - 9'd1;
                    end
                end
            endcase
            r.frame_kind   = cur_type;
            r.message_rate = rate;
            expected_q.push_back(r);
            active_items++;
        endfunction

        function int field_mismatch(string name, longint unsigned want, longint unsigned got);
            if (want == got) return 0;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1;
        endfunction

        // Compare one output transfer with the oldest prediction
        function void check_result(t_result got);
            t_result want;
            int      bad;
            if (expected_q.size() == 0) begin
                $error("result with none due: kind %0d byte %0h position %0d",
                       got.kind, got.frame_byte, got.byte_position);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            bad = field_mismatch("kind", want.kind, got.kind)
                + field_mismatch("frame_byte", want.frame_byte, got.frame_byte)
                + field_mismatch("byte_position", want.byte_position, got.byte_position)
                + field_mismatch("frame_kind", want.frame_kind, got.frame_kind)
                + field_mismatch("frame_end", want.frame_end, got.frame_end)
                + field_mismatch("message_rate", want.message_rate, got.message_rate);
            if (bad != 0) errors++;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sbfd_in_if  in_ch ();
    sbfd_out_if out_ch ();
    sbfd_cfg_if cfg_ch ();

    frame_scoreboard board = new();

    logic [BYTE_W-1:0] cur_marker   = '0;
    bit                src_idle_en  = 1'b1;
    bit                rx_stall_en  = 1'b1;
    bit                tick_mix_en  = 1'b1;
    bit                hold_off_req = 1'b0;
    int                items_sent   = 0;
    int                hold_offs    = 0;

    start_byte_frame_deframer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Sample every transfer at the clock edge and update the scoreboard
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.data);
            if (out_ch.valid && out_ch.ready) begin
                got.kind          = out_ch.kind;
                got.frame_byte    = out_ch.frame_byte;
                got.byte_position = out_ch.byte_position;
                got.frame_kind    = out_ch.frame_kind;
                got.frame_end     = out_ch.frame_end;
                got.message_rate  = out_ch.message_rate;
                board.check_result(got);
            end
            if (in_ch.valid && in_ch.ready) board.note_input(in_ch.mode, in_ch.rx_byte);
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        int n;
        out_ch.ready <= 1'b0;
        wait (i_rst_n == 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still due", board.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Offer one item, with an optional idle burst first, and hold until transfer
    task automatic send_item(input logic m, input logic [BYTE_W-1:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= m;
        in_ch.rx_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Received byte, with a tick slipped in now and then
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (tick_mix_en && $urandom_range(0, 24) == 0) send_item(MODE_TICK, 8'($urandom));
        send_item(MODE_BYTE, b);
    endtask

    // Send the first keep bytes of a frame with random type, payload and check
    task automatic send_frame(input int len, input int keep);
        logic [BYTE_W-1:0] b;
        for (int k = 0; k < len + 4 && k < keep; k++) begin
            case (k)
                0:       b = cur_marker;
                2:       b = len[BYTE_W-1:0];
                default: b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has been checked
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Finish any frame left open so the next one starts clean
    task automatic resync();
        int n;
        n = board.bytes_to_finish();
        repeat (n) send_item(MODE_BYTE, 8'h00);
    endtask

    // One random step: mostly whole frames, some cut short, noise, ticks, pauses
    task automatic random_burst();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 85) len = $urandom_range(0, 8);
        else if ($urandom_range(0, 9) < 8) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 255);
        if (r < 68) begin
            send_frame(len, len + 4);
        end else if (r < 78) begin
            send_frame(len, $urandom_range(1, len + 3));
        end else if (r < 90) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (r < 96) begin
            send_item(MODE_TICK, 8'($urandom));
        end else begin
            // capture off for a while; a frame in progress must resume afterwards
            settle();
            write_reg(REG_CAPTURE_ENABLE, {7'($urandom), 1'b0});
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            settle();
            write_reg(REG_CAPTURE_ENABLE, {7'($urandom), 1'b1});
        end
    endtask

    initial begin : stimulus
        int base;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_BYTE;
        in_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= '0;
        cfg_ch.data   <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Capture is off after reset: bytes vanish, a tick still reports
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_TICK, 8'hFF);
        settle();
        write_reg(REG_CAPTURE_ENABLE, 8'hFE);
        cur_marker = 8'hA5;
        write_reg(REG_START_MARKER, cur_marker);
        send_item(MODE_BYTE, 8'hA5);
        settle();
        write_reg(REG_SPARE_LO, 8'h00);
        write_reg(REG_SPARE_HI, 8'hFF);
        write_reg(REG_CAPTURE_ENABLE, 8'h01);

        // Noise while hunting, then a zero-length frame with extreme bytes
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, 8'hA5);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_TICK, 8'h00);

        // Tick in mid-frame, then capture off and back on before the check byte
        send_item(MODE_BYTE, 8'hA5);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_TICK, 8'h5A);
        send_item(MODE_BYTE, 8'h02);
        send_item(MODE_BYTE, 8'h7F);
        send_item(MODE_BYTE, 8'h80);
        settle();
        write_reg(REG_CAPTURE_ENABLE, 8'h00);
        send_item(MODE_BYTE, 8'hA5);
        send_item(MODE_TICK, 8'h33);
        settle();
        write_reg(REG_CAPTURE_ENABLE, 8'hFF);
        send_item(MODE_BYTE, 8'h5A);
        send_item(MODE_TICK, 8'hC3);

        // Random part, one start marker per phase
        base = board.active_items;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            resync();
            settle();
            case (p)
                0:       cur_marker = 8'h00;
                1:       cur_marker = 8'hFF;
                default: cur_marker = 8'($urandom);
            endcase
            write_reg(REG_START_MARKER, cur_marker);
            if (p == 1) send_frame(255, 259);
            if (p == 2) hold_off_req = 1'b1;
            if (p == RANDOM_PHASES - 1) begin
                src_idle_en = 1'b0;
                rx_stall_en = 1'b0;
            end
            while (board.active_items < base + RANDOM_ITEMS * (p + 1) / RANDOM_PHASES) begin
                random_burst();
                if (p == 3 && $urandom_range(0, 49) == 0) settle();
            end
        end

        // Close out with two short frames, each between two ticks
        settle();
        resync();
        tick_mix_en = 1'b0;
        send_item(MODE_TICK, 8'h00);
        send_frame(0, 4);
        send_item(MODE_TICK, 8'hFF);
        send_frame(2, 6);
        send_item(MODE_TICK, 8'h00);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end

        $display("Covered %0d input transfers, %0d results checked, %0d frames, %0d rate reports",
                 items_sent, board.results_checked, board.frames_done, board.rate_reports);
        $display("Markers 0x00, 0xFF and random; %0d long hold-off(s); peak rate %0d of %0d",
                 hold_offs, board.peak_rate, RATE_MAX);
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== start_byte_frame_deframer.f =====
sv/sbfd_pkg.sv
sv/sbfd_in_if.sv
sv/sbfd_out_if.sv
sv/sbfd_cfg_if.sv
sv/sbfd_parser.sv
sv/sbfd_out_buf.sv
sv/start_byte_frame_deframer.sv
verif/testbench.sv
